// ===== rtl/aabb_pkg.sv =====
// aabb_pkg: shared types, codes and helpers for the box move and collision block
// no dependencies; compiled first
`default_nettype none

package aabb_pkg;

  localparam int MAX_OBS_DEF = 16;

  localparam int POS_W = 20;
  localparam int CRD_W = 24;
  localparam int DIM_W = 16;

  typedef logic signed [POS_W-1:0] pos_t;
  typedef logic signed [CRD_W-1:0] coord_t;
  typedef logic [DIM_W-1:0]        dim_t;

  localparam coord_t POS_MAX_C = 24'sd524287;
  localparam coord_t POS_MIN_C = -24'sd524288;

  typedef enum logic [1:0] {
    REQ_LOAD  = 2'd0,
    REQ_PLACE = 2'd1,
    REQ_MOVE  = 2'd2,
    REQ_NOP   = 2'd3
  } req_kind_t;

  typedef enum logic [1:0] {
    CFG_BOX_W  = 2'd0,
    CFG_BOX_H  = 2'd1,
    CFG_SPEED  = 2'd2,
    CFG_ACTIVE = 2'd3
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_NEXT,
    ST_BOX,
    ST_SCAN,
    ST_RES1,
    ST_RES2,
    ST_RES3,
    ST_DONE
  } state_t;

  // one obstacle table entry
  typedef struct packed {
    pos_t x;
    pos_t y;
    dim_t w;
    dim_t h;
  } obs_t;

  // moving box corners at the candidate position
  typedef struct packed {
    coord_t x0;
    coord_t y0;
    coord_t x1;
    coord_t y1;
  } box_t;

  // overlap unit result
  typedef struct packed {
    logic   hit;
    coord_t left;
    coord_t right;
    coord_t top;
    coord_t bot;
  } ovl_t;

  function automatic pos_t sat_pos(input coord_t v);
    pos_t r;
    if (v > POS_MAX_C) begin
      r = POS_MAX_C[POS_W-1:0];
    end else if (v < POS_MIN_C) begin
      r = POS_MIN_C[POS_W-1:0];
    end else begin
      r = v[POS_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/aabb_if.sv =====
// aabb channel interfaces: request, result and register write words
// depends on aabb_pkg
`default_nettype none

interface aabb_req_if import aabb_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [1:0]             req_type;
  logic [3:0]             slot;
  logic signed [POS_W-1:0] rect_x;
  logic signed [POS_W-1:0] rect_y;
  logic [DIM_W-1:0]       rect_w;
  logic [DIM_W-1:0]       rect_h;
  logic signed [1:0]      x_dir;
  logic signed [1:0]      y_dir;
  logic [15:0]            delta_time;

  modport source (output valid, req_type, slot, rect_x, rect_y, rect_w, rect_h,
                  x_dir, y_dir, delta_time, input ready);
  modport sink (input valid, req_type, slot, rect_x, rect_y, rect_w, rect_h,
                x_dir, y_dir, delta_time, output ready);
endinterface

interface aabb_rsp_if import aabb_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [POS_W-1:0] box_x;
  logic signed [POS_W-1:0] box_y;
  logic                    collided;
  logic [3:0]              hit_slot;

  modport source (output valid, box_x, box_y, collided, hit_slot, input ready);
  modport sink (input valid, box_x, box_y, collided, hit_slot, output ready);
endinterface

interface aabb_cfg_if ();
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/aabb_obs_ram.sv =====
// aabb_obs_ram: obstacle table, one write port and one registered read port
// depends on aabb_pkg
`default_nettype none

module aabb_obs_ram import aabb_pkg::*; #(
  parameter int  DEPTH = MAX_OBS_DEF,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire obs_t          wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output obs_t               rd_data
);

  obs_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/aabb_ovl.sv =====
// aabb_ovl: shared overlap unit, strict box test and the four signed overlaps
// depends on aabb_pkg
`default_nettype none

module aabb_ovl import aabb_pkg::*; (
  input  wire box_t box,
  input  wire obs_t obs,
  output ovl_t      res
);

  coord_t ox0, oy0, ox1, oy1;

  always_comb begin
    ox0 = coord_t'(obs.x);
    oy0 = coord_t'(obs.y);
    ox1 = ox0 + coord_t'(obs.w);
    oy1 = oy0 + coord_t'(obs.h);
    res.hit   = (box.x0 < ox1) && (ox0 < box.x1) && (box.y0 < oy1) && (oy0 < box.y1);
    res.left  = box.x1 - ox0;
    res.right = ox1 - box.x0;
    res.top   = box.y1 - oy0;
    res.bot   = oy1 - box.y0;
  end

endmodule

`default_nettype wire

// ===== rtl/aabb_move_collision_resolver.sv =====
// aabb_move_collision_resolver: top level, sequencer, registers and datapath
// depends on aabb_pkg, aabb_if, aabb_obs_ram, aabb_ovl
// accept to result: load, place and no-op words go straight to the done step; a move passes
//   multiply, next position and box corners, then scans the active slots until the first hit
//   (if any), resolves a hit through RES1 to RES3, then done; one word at a time, the next taken
//   in the cycle after its result loads; a waiting result holds the next word in its done step
// reset clears the sequencer and box position and restores register defaults; table undefined

`default_nettype none

module aabb_move_collision_resolver import aabb_pkg::*; #(
  parameter int MAX_OBSTACLES = MAX_OBS_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  aabb_req_if.sink   req,
  aabb_rsp_if.source rsp,
  aabb_cfg_if.sink   cfg
);

  localparam int AW    = (MAX_OBSTACLES > 1) ? $clog2(MAX_OBSTACLES) : 1;
  localparam int CNT_W = $clog2(MAX_OBSTACLES + 1);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_OBSTACLES);

  // configuration registers
  dim_t       box_w;
  dim_t       box_h;
  dim_t       speed;
  logic [4:0] act_cnt;

  // architectural position
  pos_t pos_x;
  pos_t pos_y;

  // sequencer
  state_t state, state_next;

  // move word latched at accept
  logic [1:0]  x_dir;
  logic [1:0]  y_dir;
  logic [15:0] dt;
  logic [15:0] mag;

  // working position and box corners
  pos_t   nx;
  pos_t   ny;
  coord_t px1;
  coord_t py1;

  // scan control
  logic [CNT_W-1:0] scan_cnt;
  logic [CNT_W-1:0] issue_idx;
  logic [CNT_W-1:0] tst_idx;
  logic             tst_vld;
  logic             rd_en;
  logic             wr_en;
  logic             slot_ok;
  logic             scan_last;

  // resolve pipeline
  ovl_t   hit_ovl;
  coord_t mx;
  coord_t my;
  logic   sel_x;
  coord_t cand_x;
  coord_t cand_y;
  logic       res_col;
  logic [3:0] res_slot;

  // result register
  logic       out_vld;
  pos_t       out_x;
  pos_t       out_y;
  logic       out_col;
  logic [3:0] out_slot;

  obs_t   wr_data;
  obs_t   rd_data;
  box_t   box;
  ovl_t   ovl;
  coord_t disp_x;
  coord_t disp_y;
  coord_t abs_mx;
  coord_t abs_my;
  logic [31:0] prod;

  // -------------------------------------------------------------------------
  // obstacle table and shared overlap unit

  assign slot_ok = int'(req.slot) < MAX_OBSTACLES;

  assign wr_data.x = req.rect_x;
  assign wr_data.y = req.rect_y;
  assign wr_data.w = req.rect_w;
  assign wr_data.h = req.rect_h;

  aabb_obs_ram #(
    .DEPTH (MAX_OBSTACLES)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (AW'(req.slot)),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (issue_idx[AW-1:0]),
    .rd_data (rd_data)
  );

  assign box.x0 = coord_t'(nx);
  assign box.y0 = coord_t'(ny);
  assign box.x1 = px1;
  assign box.y1 = py1;

  aabb_ovl u_ovl (
    .box (box),
    .obs (rd_data),
    .res (ovl)
  );

  // -------------------------------------------------------------------------
  // handshakes

  assign req.ready = (state == ST_IDLE);
  assign cfg.ready = 1'b1;

  assign rsp.valid    = out_vld;
  assign rsp.box_x    = out_x;
  assign rsp.box_y    = out_y;
  assign rsp.collided = out_col;
  assign rsp.hit_slot = out_slot;

  // -------------------------------------------------------------------------
  // datapath helpers

  // speed * dt, upper half is the displacement magnitude
  assign prod = speed * dt;

  // pattern 10 counts as minus one
  always_comb begin
    if (x_dir == 2'b00) begin
      disp_x = '0;
    end else if (x_dir[1]) begin
      disp_x = -coord_t'(mag);
    end else begin
      disp_x = coord_t'(mag);
    end
    if (y_dir == 2'b00) begin
      disp_y = '0;
    end else if (y_dir[1]) begin
      disp_y = -coord_t'(mag);
    end else begin
      disp_y = coord_t'(mag);
    end
  end

  assign abs_mx = mx[CRD_W-1] ? -mx : mx;
  assign abs_my = my[CRD_W-1] ? -my : my;

  assign scan_last = (tst_idx + 1'b1) == scan_cnt;

  // -------------------------------------------------------------------------
  // sequencer

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    rd_en      = 1'b0;
    wr_en      = 1'b0;
    case (state)
      ST_IDLE: begin
        if (req.valid) begin
          wr_en = (req.req_type == REQ_LOAD) && slot_ok;
          if (req.req_type == REQ_MOVE) begin
            state_next = ST_MUL;
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      ST_MUL:  state_next = ST_NEXT;
      ST_NEXT: state_next = ST_BOX;
      ST_BOX: begin
        if (scan_cnt == '0) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // one read issued per cycle, tested the cycle after
        rd_en = issue_idx < scan_cnt;
        if (tst_vld && ovl.hit) begin
          state_next = ST_RES1;
        end else if (tst_vld && scan_last) begin
          state_next = ST_DONE;
        end
      end
      ST_RES1: state_next = ST_RES2;
      ST_RES2: state_next = ST_RES3;
      ST_RES3: state_next = ST_DONE;
      ST_DONE: begin
        if (!out_vld || rsp.ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // -------------------------------------------------------------------------
  // configuration registers

  always_ff @(posedge clk) begin
    if (rst) begin
      box_w   <= 16'd512;
      box_h   <= 16'd512;
      speed   <= 16'd1600;
      act_cnt <= 5'd0;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_BOX_W:  box_w   <= cfg.data;
        CFG_BOX_H:  box_h   <= cfg.data;
        CFG_SPEED:  speed   <= cfg.data;
        CFG_ACTIVE: act_cnt <= cfg.data[4:0];
        default:    box_w   <= box_w;
      endcase
    end
  end

  // -------------------------------------------------------------------------
  // control registers: position, scan progress, result valid

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x   <= '0;
      pos_y   <= '0;
      tst_vld <= 1'b0;
      out_vld <= 1'b0;
    end else begin
      // a new result replaces the one taken this cycle
      if (state == ST_DONE && (!out_vld || rsp.ready)) begin
        out_vld <= 1'b1;
        pos_x   <= nx;
        pos_y   <= ny;
      end else if (rsp.ready) begin
        out_vld <= 1'b0;
      end
      tst_vld <= rd_en;
    end
  end

  // -------------------------------------------------------------------------
  // working registers

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        res_col   <= 1'b0;
        res_slot  <= '0;
        x_dir     <= req.x_dir;
        y_dir     <= req.y_dir;
        dt        <= req.delta_time;
        issue_idx <= '0;
        if (int'(act_cnt) > MAX_OBSTACLES) begin
          scan_cnt <= MAX_CNT;
        end else begin
          scan_cnt <= CNT_W'(act_cnt);
        end
        if (req.req_type == REQ_PLACE) begin
          nx <= req.rect_x;
          ny <= req.rect_y;
        end else begin
          nx <= pos_x;
          ny <= pos_y;
        end
      end
      ST_MUL: begin
        mag <= prod[31:16];
      end
      ST_NEXT: begin
        nx <= sat_pos(coord_t'(pos_x) + disp_x);
        ny <= sat_pos(coord_t'(pos_y) + disp_y);
      end
      ST_BOX: begin
        px1 <= coord_t'(nx) + coord_t'(box_w);
        py1 <= coord_t'(ny) + coord_t'(box_h);
      end
      ST_SCAN: begin
        if (rd_en) begin
          issue_idx <= issue_idx + 1'b1;
        end
        tst_idx <= issue_idx;
        if (tst_vld && ovl.hit) begin
          hit_ovl  <= ovl;
          res_col  <= 1'b1;
          res_slot <= 4'(tst_idx);
        end
      end
      ST_RES1: begin
        // signed minimum overlap on each axis
        mx <= (hit_ovl.left < hit_ovl.right) ? hit_ovl.left : -hit_ovl.right;
        my <= (hit_ovl.top < hit_ovl.bot) ? hit_ovl.top : -hit_ovl.bot;
      end
      ST_RES2: begin
        // ties push along y
        sel_x  <= abs_mx < abs_my;
        cand_x <= coord_t'(nx) - mx;
        cand_y <= coord_t'(ny) - my;
      end
      ST_RES3: begin
        if (sel_x) begin
          nx <= sat_pos(cand_x);
        end else begin
          ny <= sat_pos(cand_y);
        end
      end
      ST_DONE: begin
        if (!out_vld || rsp.ready) begin
          out_x    <= nx;
          out_y    <= ny;
          out_col  <= res_col;
          out_slot <= res_slot;
        end
      end
      default: mag <= mag;
    endcase
  end

  // -------------------------------------------------------------------------
  // checks

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_SCAN |-> issue_idx <= scan_cnt)
    else $error("scan issued past the active count");

  a_tst_bound: assert property (@(posedge clk) disable iff (rst)
    tst_vld |-> tst_idx < scan_cnt)
    else $error("tested a slot beyond the active count");

  a_rsp_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_vld) |-> $past(state) == ST_DONE)
    else $error("result raised outside the done step");

  a_read_only_scan: assert property (@(posedge clk) disable iff (rst)
    rd_en |-> state == ST_SCAN && !wr_en)
    else $error("table read outside the scan");

endmodule

`default_nettype wire
